// ===== rtl/mmd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmd_pkg
// Shared types and constants for the matrix dot-product core.
// ----------------------------------------------------------------------------
package mmd_pkg;

    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 32;
    localparam int DOT_W      = 36;
    localparam int IDX_W      = 4;
    localparam int DIM_REG_W  = 5;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE_A = 2'd0,
        KIND_WRITE_B = 2'd1,
        KIND_READ    = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_LEN = 2'd1,
        CFG_COLS_B    = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic read_err;
        logic kn_zero;
        logic last_issue;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/mmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmd_ctrl
// Sequencer: takes items, steps the multiply-accumulate, loads the result.
// ----------------------------------------------------------------------------
module mmd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mmd_pkg::status_t status,
    output mmd_pkg::cmd_t    cmd
);

    mmd_pkg::state_t state_reg;
    mmd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            mmd_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.is_read)
                begin
                    // error reads and empty sums skip the accumulate loop
                    if (status.read_err || status.kn_zero)
                    begin
                        state_next = mmd_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = mmd_pkg::ST_RUN;
                    end
                end
            end
            mmd_pkg::ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (status.last_issue)
                begin
                    state_next = mmd_pkg::ST_DRAIN1;
                end
            end
            mmd_pkg::ST_DRAIN1:
            begin
                state_next = mmd_pkg::ST_DRAIN2;
            end
            mmd_pkg::ST_DRAIN2:
            begin
                state_next = mmd_pkg::ST_FINISH;
            end
            mmd_pkg::ST_FINISH:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = mmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mmd_datapath.sv =====
// ----------------------------------------------------------------------------
// mmd_datapath
// Configuration, operand stores, multiply-accumulate and output register.
// ----------------------------------------------------------------------------
module mmd_datapath
#(
    parameter int MAX_DIM = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mmd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mmd_pkg::DIM_REG_W-1:0]       cfg_data,
    input  logic [mmd_pkg::KIND_W-1:0]          in_kind,
    input  logic [mmd_pkg::IDX_W-1:0]           in_row,
    input  logic [mmd_pkg::IDX_W-1:0]           in_col,
    input  logic [mmd_pkg::ELEM_W-1:0]          in_value,
    input  mmd_pkg::cmd_t                       cmd,
    output mmd_pkg::status_t                    status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mmd_pkg::DOT_W-1:0]    out_dot,
    output logic                                out_err
);

    localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int EXT_W  = (CNT_W > mmd_pkg::DIM_REG_W) ? CNT_W : mmd_pkg::DIM_REG_W;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MUL_W  = ADDR_W + 8;

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [mmd_pkg::DIM_REG_W-1:0] v);
        logic [EXT_W-1:0] ext;
        begin
            ext = EXT_W'(v);
            if (ext > EXT_W'(MAX_DIM))
            begin
                clamp_dim = CNT_W'(MAX_DIM);
            end
            else
            begin
                clamp_dim = CNT_W'(ext);
            end
        end
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [MUL_W-1:0] r,
                                                  input logic [MUL_W-1:0] c);
        logic [MUL_W-1:0] full;
        begin
            full    = r * MUL_W'(MAX_DIM) + c;
            addr_of = full[ADDR_W-1:0];
        end
    endfunction

    logic [mmd_pkg::DIM_REG_W-1:0] rows_a_reg;
    logic [mmd_pkg::DIM_REG_W-1:0] inner_len_reg;
    logic [mmd_pkg::DIM_REG_W-1:0] cols_b_reg;

    logic [CNT_W-1:0] ra;
    logic [CNT_W-1:0] kn;
    logic [CNT_W-1:0] cb;

    logic [mmd_pkg::ELEM_W-1:0] mem_a [DEPTH];
    logic [mmd_pkg::ELEM_W-1:0] mem_b [DEPTH];

    logic                        we_a;
    logic                        we_b;
    logic [ADDR_W-1:0]           waddr;
    logic [ADDR_W-1:0]           raddr_a;
    logic [ADDR_W-1:0]           raddr_b;
    logic                        row_in_a;
    logic                        col_in_a;
    logic                        row_in_b;
    logic                        col_in_b;
    logic                        in_is_read;
    logic                        in_err;

    logic [mmd_pkg::IDX_W-1:0]   row_reg;
    logic [mmd_pkg::IDX_W-1:0]   col_reg;
    logic [CNT_W-1:0]            kn_reg;
    logic                        err_reg;
    logic [DIM_W-1:0]            j_reg;
    logic [DIM_W-1:0]            j_next;

    logic [mmd_pkg::ELEM_W-1:0]  rd_a_reg;
    logic [mmd_pkg::ELEM_W-1:0]  rd_b_reg;
    logic                        rd_valid_reg;
    logic signed [mmd_pkg::PROD_W-1:0] prod_reg;
    logic signed [mmd_pkg::PROD_W-1:0] prod_next;
    logic                        prod_valid_reg;
    logic signed [mmd_pkg::DOT_W-1:0]  acc_reg;
    logic signed [mmd_pkg::DOT_W-1:0]  acc_next;

    logic                        out_valid_reg;
    logic signed [mmd_pkg::DOT_W-1:0]  out_dot_reg;
    logic                        out_err_reg;

    assign cfg_ready = 1'b1;

    assign ra = clamp_dim(rows_a_reg);
    assign kn = clamp_dim(inner_len_reg);
    assign cb = clamp_dim(cols_b_reg);

    assign row_in_a = EXT_W'(in_row) < EXT_W'(ra);
    assign col_in_a = EXT_W'(in_col) < EXT_W'(kn);
    assign row_in_b = EXT_W'(in_row) < EXT_W'(kn);
    assign col_in_b = EXT_W'(in_col) < EXT_W'(cb);

    assign in_is_read = (in_kind == mmd_pkg::KIND_READ);
    assign in_err     = !row_in_a || !col_in_b;

    assign we_a  = cmd.accept && (in_kind == mmd_pkg::KIND_WRITE_A) && row_in_a && col_in_a;
    assign we_b  = cmd.accept && (in_kind == mmd_pkg::KIND_WRITE_B) && row_in_b && col_in_b;
    assign waddr = addr_of(MUL_W'(in_row), MUL_W'(in_col));

    // A walks along the row, B walks down the column
    assign raddr_a = addr_of(MUL_W'(row_reg), MUL_W'(j_reg));
    assign raddr_b = addr_of(MUL_W'(j_reg), MUL_W'(col_reg));

    assign j_next    = j_reg + DIM_W'(1);
    assign prod_next = $signed(rd_a_reg) * $signed(rd_b_reg);
    assign acc_next  = acc_reg + {{(mmd_pkg::DOT_W - mmd_pkg::PROD_W){prod_reg[mmd_pkg::PROD_W-1]}},
                                  prod_reg};

    assign status.is_read    = in_is_read;
    assign status.read_err   = in_err;
    assign status.kn_zero    = (kn == '0);
    assign status.last_issue = EXT_W'(j_reg) == (EXT_W'(kn_reg) - EXT_W'(1));
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= mmd_pkg::DIM_REG_W'(16);
            inner_len_reg <= mmd_pkg::DIM_REG_W'(16);
            cols_b_reg    <= mmd_pkg::DIM_REG_W'(16);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mmd_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                mmd_pkg::CFG_INNER_LEN: inner_len_reg <= cfg_data;
                mmd_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[waddr] <= in_value;
        end
        if (we_b)
        begin
            mem_b[waddr] <= in_value;
        end
        rd_a_reg <= mem_a[raddr_a];
        rd_b_reg <= mem_b[raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg          <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                j_reg <= '0;
            end
            else if (cmd.issue)
            begin
                j_reg <= j_next;
            end
            rd_valid_reg   <= cmd.issue;
            prod_valid_reg <= rd_valid_reg;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            row_reg <= in_row;
            col_reg <= in_col;
            kn_reg  <= kn;
            err_reg <= in_err;
        end
        prod_reg <= prod_next;
        if (cmd.accept)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.load)
        begin
            out_dot_reg <= err_reg ? '0 : acc_reg;
            out_err_reg <= err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_dot   = out_dot_reg;
    assign out_err   = out_err_reg;

endmodule

// ===== rtl/matrix_multiply_dot_core.sv =====
// A read item runs the single multiply-accumulate over kn products (kn = inner length
// clamped to MAX_DIM); an out-of-range read or kn of zero skips it. Items are taken only
// in idle, so after a read no new item is accepted until its result is loaded into the
// output register, which waits for that register to be free. Writes never leave idle.
// Each store has one registered read port. Reset: rows_a, inner_len and cols_b return
// to 16; the operand stores are not cleared, so the block accepts items straight after reset.
// ----------------------------------------------------------------------------
// matrix_multiply_dot_core
// Two element-loaded operand matrices with row-by-column dot-product readout.
// ----------------------------------------------------------------------------
module matrix_multiply_dot_core
#(
    parameter int MAX_DIM = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mmd_pkg::DIM_REG_W-1:0]     cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mmd_pkg::IN_DATA_W-1:0]     s_tdata,   // row_index, col_index, element_value
    input  logic [mmd_pkg::KIND_W-1:0]        s_tuser,   // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mmd_pkg::OUT_DATA_W-1:0]    m_tdata,   // dot_value, zero fill
    output logic                              m_tuser    // index_error
);

    mmd_pkg::cmd_t                     cmd;
    mmd_pkg::status_t                  status;
    logic signed [mmd_pkg::DOT_W-1:0]  dot;

    mmd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mmd_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_kind   (s_tuser),
        .in_row    (s_tdata[3:0]),
        .in_col    (s_tdata[7:4]),
        .in_value  (s_tdata[23:8]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_dot   (dot),
        .out_err   (m_tuser)
    );

    assign m_tdata = {{(mmd_pkg::OUT_DATA_W - mmd_pkg::DOT_W){1'b0}}, dot};

endmodule
